[rtl/core/qpac_pkg.sv]
package qpac_pkg;

   typedef logic [63:0] word_type;
   typedef logic [3:0]  nib_type;

   // Cipher state and tweak as they travel down the pipeline.
   typedef struct packed {
      word_type t;
      word_type w;
   } blk_type;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_idx_type;

   localparam int NumRounds = 5;

   localparam word_type ALPHA = 64'hC0AC29B7C97C50DD;
   localparam word_type RC [NumRounds] = '{
      64'h0000000000000000, 64'h13198A2E03707344, 64'hA4093822299F31D0,
      64'h082EFA98EC4E6C89, 64'h452821E638D01377
   };

   localparam nib_type SBOX_FWD [16] = '{
      4'hB, 4'h6, 4'h8, 4'hF, 4'hC, 4'h0, 4'h9, 4'hE,
      4'h3, 4'h7, 4'h4, 4'h5, 4'hD, 4'h2, 4'h1, 4'hA
   };
   localparam nib_type SBOX_INV [16] = '{
      4'h5, 4'hE, 4'hD, 4'h8, 4'hA, 4'hB, 4'h1, 4'h9,
      4'h2, 4'h6, 4'hF, 4'h0, 4'h4, 4'hC, 4'h7, 4'h3
   };

   // Source cell for each destination cell.
   localparam nib_type PERM_FWD [16] = '{
      4'd13, 4'd6, 4'd11, 4'd0, 4'd7, 4'd12, 4'd1, 4'd10,
      4'd8, 4'd3, 4'd14, 4'd5, 4'd2, 4'd9, 4'd4, 4'd15
   };
   localparam nib_type PERM_INV [16] = '{
      4'd3, 4'd6, 4'd12, 4'd9, 4'd14, 4'd11, 4'd1, 4'd4,
      4'd8, 4'd13, 4'd7, 4'd2, 4'd5, 4'd0, 4'd10, 4'd15
   };
   localparam nib_type TWK_FWD [16] = '{
      4'd4, 4'd5, 4'd6, 4'd7, 4'd11, 4'd2, 4'd3, 4'd8,
      4'd12, 4'd13, 4'd14, 4'd15, 4'd0, 4'd1, 4'd10, 4'd9
   };
   localparam nib_type TWK_INV [16] = '{
      4'd12, 4'd13, 4'd5, 4'd6, 4'd0, 4'd1, 4'd2, 4'd3,
      4'd7, 4'd15, 4'd14, 4'd4, 4'd8, 4'd9, 4'd10, 4'd11
   };

   // Destination cells that take an LFSR step during the tweak update.
   localparam logic [15:0] TWK_FWD_LFSR = 16'hD894;
   localparam logic [15:0] TWK_INV_LFSR = 16'h8F41;

   function automatic word_type permute(word_type x, nib_type src [16]);
      word_type y;
      y = '0;
      for (int c = 0; c < 16; c++) begin
         y[4*c +: 4] = x[4*src[c[3:0]] +: 4];
      end
      return y;
   endfunction

   function automatic word_type sub_cells(word_type x, nib_type box [16]);
      word_type y;
      y = '0;
      for (int c = 0; c < 16; c++) begin
         y[4*c +: 4] = box[x[4*c +: 4]];
      end
      return y;
   endfunction

   function automatic nib_type rotl1(nib_type v);
      return {v[2:0], v[3]};
   endfunction

   function automatic nib_type rotl2(nib_type v);
      return {v[1:0], v[3:2]};
   endfunction

   // Column multiply over rotated cells; each of the four results lands in its own row.
   function automatic word_type mix_columns(word_type x);
      word_type y;
      nib_type a0, a1, a2, a3;
      y = '0;
      for (int col = 0; col < 4; col++) begin
         a0 = x[4*col +: 4];
         a1 = x[4*(col + 4) +: 4];
         a2 = x[4*(col + 8) +: 4];
         a3 = x[4*(col + 12) +: 4];
         y[4*(col + 12) +: 4] = rotl1(a2) ^ rotl2(a1) ^ rotl1(a0);
         y[4*(col + 8) +: 4]  = rotl1(a3) ^ rotl1(a1) ^ rotl2(a0);
         y[4*(col + 4) +: 4]  = rotl2(a3) ^ rotl1(a2) ^ rotl1(a0);
         y[4*col +: 4]        = rotl1(a3) ^ rotl2(a2) ^ rotl1(a1);
      end
      return y;
   endfunction

   function automatic word_type tweak_fwd(word_type x);
      word_type y;
      nib_type v;
      y = '0;
      for (int c = 0; c < 16; c++) begin
         v = x[4*TWK_FWD[c[3:0]] +: 4];
         if (TWK_FWD_LFSR[c[3:0]]) begin
            v = {v[0] ^ v[1], v[3:1]};
         end
         y[4*c +: 4] = v;
      end
      return y;
   endfunction

   function automatic word_type tweak_inv(word_type x);
      word_type y;
      nib_type v;
      y = '0;
      for (int c = 0; c < 16; c++) begin
         v = x[4*TWK_INV[c[3:0]] +: 4];
         if (TWK_INV_LFSR[c[3:0]]) begin
            v = {v[2:0], v[0] ^ v[3]};
         end
         y[4*c +: 4] = v;
      end
      return y;
   endfunction

endpackage

[rtl/core/qpac_fwd_round.sv]
// One forward round with its own pipeline register.
module qpac_fwd_round (
   input  logic              clock,
   input  logic              reset,
   input  qpac_pkg::word_type key_core,
   input  qpac_pkg::word_type rc,
   input  logic              mix_en,
   input  logic              in_valid,
   output logic              in_ready,
   input  qpac_pkg::blk_type in_blk,
   output logic              out_valid,
   input  logic              out_ready,
   output qpac_pkg::blk_type out_blk
);

   logic              valid_ff;
   logic              valid_in;
   qpac_pkg::blk_type blk_ff;
   qpac_pkg::blk_type blk_in;
   qpac_pkg::word_type w_add;
   qpac_pkg::word_type w_mix;

   // The stage takes a new item when it is empty or its content moves on.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Add round tweakey, optional shuffle and column multiply, then the S-box.
   always_comb begin
      w_add = in_blk.w ^ key_core ^ in_blk.t ^ rc;
      w_mix = mix_en ? qpac_pkg::mix_columns(qpac_pkg::permute(w_add, qpac_pkg::PERM_FWD))
                     : w_add;
      blk_in.w = qpac_pkg::sub_cells(w_mix, qpac_pkg::SBOX_FWD);
      blk_in.t = qpac_pkg::tweak_fwd(in_blk.t);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         blk_ff <= blk_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_blk   = blk_ff;

endmodule

[rtl/core/qpac_center.sv]
// Central reflector, split over two pipeline registers.
module qpac_center (
   input  logic              clock,
   input  logic              reset,
   input  qpac_pkg::word_type key_white,
   input  qpac_pkg::word_type key_white_m,
   input  qpac_pkg::word_type key_core,
   input  logic              in_valid,
   output logic              in_ready,
   input  qpac_pkg::blk_type in_blk,
   output logic              out_valid,
   input  logic              out_ready,
   output qpac_pkg::blk_type out_blk
);

   logic              a_valid_ff;
   logic              a_valid_in;
   logic              a_ready;
   qpac_pkg::blk_type a_blk_ff;
   qpac_pkg::blk_type a_blk_in;
   logic              b_valid_ff;
   logic              b_valid_in;
   qpac_pkg::blk_type b_blk_ff;
   qpac_pkg::blk_type b_blk_in;
   qpac_pkg::word_type w_a;
   qpac_pkg::word_type w_b0;
   qpac_pkg::word_type w_b1;

   assign a_ready    = !b_valid_ff || out_ready;
   assign in_ready   = !a_valid_ff || a_ready;
   assign a_valid_in = in_ready ? in_valid : a_valid_ff;
   assign b_valid_in = a_ready ? a_valid_ff : b_valid_ff;

   // First half: whitening with the derived key, shuffle, multiply, S-box.
   always_comb begin
      w_a = in_blk.w ^ key_white_m ^ in_blk.t;
      a_blk_in.w = qpac_pkg::sub_cells(
         qpac_pkg::mix_columns(qpac_pkg::permute(w_a, qpac_pkg::PERM_FWD)),
         qpac_pkg::SBOX_FWD);
      a_blk_in.t = in_blk.t;
   end

   // Second half: shuffle, multiply, core key, inverse shuffle and S-box, back out.
   always_comb begin
      w_b0 = qpac_pkg::mix_columns(qpac_pkg::permute(a_blk_ff.w, qpac_pkg::PERM_FWD))
             ^ key_core;
      w_b1 = qpac_pkg::sub_cells(qpac_pkg::permute(w_b0, qpac_pkg::PERM_INV),
                                 qpac_pkg::SBOX_INV);
      b_blk_in.w = qpac_pkg::permute(qpac_pkg::mix_columns(w_b1), qpac_pkg::PERM_INV)
                   ^ key_white ^ a_blk_ff.t;
      b_blk_in.t = a_blk_ff.t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         a_blk_ff <= a_blk_in;
      end
      if (a_ready && a_valid_ff) begin
         b_blk_ff <= b_blk_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_blk   = b_blk_ff;

endmodule

[rtl/core/qpac_inv_round.sv]
// One inverse round with its own pipeline register.
module qpac_inv_round (
   input  logic              clock,
   input  logic              reset,
   input  qpac_pkg::word_type key_core,
   input  qpac_pkg::word_type rc,
   input  qpac_pkg::word_type post_key,
   input  logic              mix_en,
   input  logic              in_valid,
   output logic              in_ready,
   input  qpac_pkg::blk_type in_blk,
   output logic              out_valid,
   input  logic              out_ready,
   output qpac_pkg::blk_type out_blk
);

   logic              valid_ff;
   logic              valid_in;
   qpac_pkg::blk_type blk_ff;
   qpac_pkg::blk_type blk_in;
   qpac_pkg::word_type w_sub;
   qpac_pkg::word_type w_mix;
   qpac_pkg::word_type t_next;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Inverse S-box, optional multiply and inverse shuffle, then the round tweakey.
   always_comb begin
      w_sub  = qpac_pkg::sub_cells(in_blk.w, qpac_pkg::SBOX_INV);
      w_mix  = mix_en ? qpac_pkg::permute(qpac_pkg::mix_columns(w_sub), qpac_pkg::PERM_INV)
                      : w_sub;
      t_next = qpac_pkg::tweak_inv(in_blk.t);
      blk_in.w = w_mix ^ rc ^ key_core ^ t_next ^ qpac_pkg::ALPHA ^ post_key;
      blk_in.t = t_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         blk_ff <= blk_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_blk   = blk_ff;

endmodule

[rtl/core/qarma5_pac_cipher_top.sv]
// QARMA-64 cipher with five rounds per half, as used for pointer authentication.
// Input stream (req_): one transfer carries a data word and its tweak. Output
// stream (rsp_): one transfer carries the 64-bit cipher output for each input,
// in input order. The 128-bit key sits in two registers written through the
// csr_ port (index 0 key_high, index 1 key_low); write them only while no item
// is in flight.
// The datapath is a twelve-stage pipeline: five forward rounds, a reflector
// split over two stages, and five inverse rounds, one register per stage with
// the last one driving rsp_. One item can enter every cycle while rsp_tready
// stays high.
// Each stage holds its item while the stage after it is full and stalled, so
// when the receiver drops rsp_tready the bubbles ahead of the stall still fill
// and req_tready falls only once every stage holds an item. Nothing is lost or
// repeated across a stall.
// Reset clears every stage valid bit and both key registers to zero.
module qarma5_pac_cipher_top (
   input  logic         clock,
   input  logic         reset,
   // Input stream.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // [63:0] data_in, [127:64] tweak
   // Result stream.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // [63:0] cipher_out
   // Key register writes.
   input  logic         csr_we,
   input  logic [0:0]   csr_addr,
   input  logic [63:0]  csr_wdata
);

   localparam int NumRounds = qpac_pkg::NumRounds;

   qpac_pkg::word_type key_high_ff;
   qpac_pkg::word_type key_low_ff;
   qpac_pkg::word_type key_high_m;

   logic              fwd_valid [NumRounds + 1];
   logic              fwd_ready [NumRounds + 1];
   qpac_pkg::blk_type fwd_blk   [NumRounds + 1];
   logic              inv_valid [NumRounds + 1];
   logic              inv_ready [NumRounds + 1];
   qpac_pkg::blk_type inv_blk   [NumRounds + 1];

   // Key registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_we) begin
         unique case (qpac_pkg::csr_idx_type'(csr_addr))
            qpac_pkg::CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            qpac_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Derived whitening key: rotate right by one, folding the top bit into bit 0.
   assign key_high_m = {key_high_ff[0], key_high_ff[63:2], key_high_ff[1] ^ key_high_ff[63]};

   // Pipeline entry, with the initial whitening.
   assign fwd_valid[0] = req_tvalid;
   assign req_tready   = fwd_ready[0];
   assign fwd_blk[0].w = req_tdata[63:0] ^ key_high_ff;
   assign fwd_blk[0].t = req_tdata[127:64];

   // Forward rounds.
   for (genvar i = 0; i < NumRounds; i++) begin : g_fwd
      qpac_fwd_round u_fwd (
         .clock     (clock),
         .reset     (reset),
         .key_core  (key_low_ff),
         .rc        (qpac_pkg::RC[i]),
         .mix_en    (1'(i != 0)),
         .in_valid  (fwd_valid[i]),
         .in_ready  (fwd_ready[i]),
         .in_blk    (fwd_blk[i]),
         .out_valid (fwd_valid[i + 1]),
         .out_ready (fwd_ready[i + 1]),
         .out_blk   (fwd_blk[i + 1])
      );
   end

   // Reflector.
   qpac_center u_center (
      .clock       (clock),
      .reset       (reset),
      .key_white   (key_high_ff),
      .key_white_m (key_high_m),
      .key_core    (key_low_ff),
      .in_valid    (fwd_valid[NumRounds]),
      .in_ready    (fwd_ready[NumRounds]),
      .in_blk      (fwd_blk[NumRounds]),
      .out_valid   (inv_valid[0]),
      .out_ready   (inv_ready[0]),
      .out_blk     (inv_blk[0])
   );

   // Inverse rounds; the last one also applies the final whitening.
   for (genvar i = 0; i < NumRounds; i++) begin : g_inv
      qpac_inv_round u_inv (
         .clock     (clock),
         .reset     (reset),
         .key_core  (key_low_ff),
         .rc        (qpac_pkg::RC[NumRounds - 1 - i]),
         .post_key  ((i == NumRounds - 1) ? key_high_m : '0),
         .mix_en    (1'(i != NumRounds - 1)),
         .in_valid  (inv_valid[i]),
         .in_ready  (inv_ready[i]),
         .in_blk    (inv_blk[i]),
         .out_valid (inv_valid[i + 1]),
         .out_ready (inv_ready[i + 1]),
         .out_blk   (inv_blk[i + 1])
      );
   end

   // Result stream.
   assign rsp_tvalid           = inv_valid[NumRounds];
   assign inv_ready[NumRounds] = rsp_tready;
   assign rsp_tdata            = inv_blk[NumRounds].w;

   // A key write lands in the addressed register on the next cycle.
   a_key_high_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_addr == qpac_pkg::CSR_KEY_HIGH |=> key_high_ff == $past(csr_wdata))
      else $error("key_high write not taken");

   a_key_low_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_addr == qpac_pkg::CSR_KEY_LOW |=> key_low_ff == $past(csr_wdata))
      else $error("key_low write not taken");

   // With the receiver ready, every stage drains, so the input side must be open.
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while the output side is ready");

   // No result may appear right after reset.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
